// ===== design/i2cs_pkg.sv =====
// Shared types and constants for the I2C slave byte sequencer.
// No dependencies; used by i2cs_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cs_pkg;

   // Buffer depth default and field widths
   localparam int TX_DEPTH_DEFAULT = 16;
   localparam int LEN_W            = 5;
   localparam int CSR_IDX_W        = 2;

   // Event codes on req_func
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_SHIFT = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_LOAD  = 2'd3;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TOP = 2'd1;

   // Shift window codes
   localparam logic [7:0] ACK_BYTE     = 8'h00;
   localparam logic [7:0] NACK_BYTE    = 8'hFF;
   localparam logic [7:0] GENERAL_CALL = 8'h00;
   localparam logic [3:0] BITS_NONE    = 4'd0;
   localparam logic [3:0] BITS_ACK     = 4'd1;
   localparam logic [3:0] BITS_DATA    = 4'd8;
   localparam logic [7:0] TIMEOUT_RESET = 8'd100;

   // One result beat; shift_value comes from the buffer read when from_mem is set
   typedef struct packed {
      logic [2:0] bus_phase;
      logic       sda_drive;
      logic [7:0] shift_value;
      logic [3:0] shift_bits;
      logic       from_mem;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [7:0] rx_index;
      logic       addressed_read;
      logic       timed_out;
   } result_type;

endpackage

`default_nettype wire

// ===== design/i2c_slave_byte_sequencer_core.sv =====
// I2C slave byte sequencer, top level: sequencer, transmit buffer, result register.
// Depends on i2cs_pkg, i2cs_seq and i2cs_txbuf.
//
// Usage: each req beat is one bus event (start, shift window done, timeout
// tick, transmit byte load). Each event yields exactly one rsp beat giving the
// next shift window (drive, value, bit count) plus receive, read-addressing
// and timeout pulses. Beats move on valid high and stall low.
// The result of a beat is registered: taken at an edge, it is on rsp from that
// edge onward. Throughput is one event per cycle while no result waits on a
// stalled rsp; the transmit buffer is read in the same cycle the data window
// is chosen, its registered read data feeding rsp_shift_value directly.
// When rsp is stalled with a result waiting, req_stall rises and no event is
// taken; otherwise a new event is taken while the old result leaves.
// The csr port (ready always high) writes own_address (index 0) and
// timeout_top (index 1); write only while no event is in flight.
// Reset (synchronous, active high) puts the sequencer in the address phase
// with counters cleared, timeout_top at 100 and no result pending. The buffer
// has no reset; its slots hold data only once loaded.
`timescale 1ns / 1ps
`default_nettype none

module i2c_slave_byte_sequencer_core #(
   parameter int TX_DEPTH = i2cs_pkg::TX_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_func,
   input  wire logic [7:0]                     req_shift_data,
   input  wire logic                           req_reject,
   input  wire logic [7:0]                     req_tx_byte,
   input  wire logic [3:0]                     req_tx_index,
   input  wire logic [i2cs_pkg::LEN_W-1:0]     req_tx_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [2:0]                     rsp_bus_phase,
   output logic                                rsp_sda_drive,
   output logic      [7:0]                     rsp_shift_value,
   output logic      [3:0]                     rsp_shift_bits,
   output logic                                rsp_rx_valid,
   output logic      [7:0]                     rsp_rx_byte,
   output logic      [7:0]                     rsp_rx_index,
   output logic                                rsp_addressed_read,
   output logic                                rsp_timed_out,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [i2cs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata
);

   localparam int ADDR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   logic                 req_accept;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [7:0]           mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [7:0]           mem_rdata;
   i2cs_pkg::result_type result;
   i2cs_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Stall input only while a result waits on a stalled receiver
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   i2cs_seq #(
      .TX_DEPTH (TX_DEPTH),
      .ADDR_W   (ADDR_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .func       (req_func),
      .shift_data (req_shift_data),
      .reject     (req_reject),
      .tx_byte    (req_tx_byte),
      .tx_index   (req_tx_index),
      .tx_count   (req_tx_count),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .result     (result)
   );

   i2cs_txbuf #(
      .DEPTH  (TX_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_txbuf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Result register: load on accept, hold while stalled, drop when taken
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result;
      end
   end

   // Data windows take the byte straight from the buffer read register
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bus_phase      = rsp_ff.bus_phase;
   assign rsp_sda_drive      = rsp_ff.sda_drive;
   assign rsp_shift_value    = rsp_ff.from_mem ? mem_rdata : rsp_ff.shift_value;
   assign rsp_shift_bits     = rsp_ff.shift_bits;
   assign rsp_rx_valid       = rsp_ff.rx_valid;
   assign rsp_rx_byte        = rsp_ff.rx_byte;
   assign rsp_rx_index       = rsp_ff.rx_index;
   assign rsp_addressed_read = rsp_ff.addressed_read;
   assign rsp_timed_out      = rsp_ff.timed_out;

`ifndef SYNTHESIS
   a_mem_window_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ff.from_mem |-> rsp_sda_drive && rsp_shift_bits == i2cs_pkg::BITS_DATA)
      else $error("buffer byte selected outside a driven data window");
`endif

endmodule

`default_nettype wire

// ===== design/i2cs_txbuf.sv =====
// Transmit byte buffer: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i2cs_txbuf #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] buf_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write on load; read into the output register when a data window is chosen
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/i2cs_seq.sv =====
// Bus phase sequencer: phase, counters, staged length, window and config registers.
// Depends on i2cs_pkg; drives the transmit buffer ports.
`timescale 1ns / 1ps
`default_nettype none

module i2cs_seq #(
   parameter int TX_DEPTH = i2cs_pkg::TX_DEPTH_DEFAULT,
   parameter int ADDR_W   = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic [1:0]                     func,
   input  wire logic [7:0]                     shift_data,
   input  wire logic                           reject,
   input  wire logic [7:0]                     tx_byte,
   input  wire logic [3:0]                     tx_index,
   input  wire logic [i2cs_pkg::LEN_W-1:0]     tx_count,
   input  wire logic                           csr_we,
   input  wire logic [i2cs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata,
   output logic                                mem_we,
   output logic      [ADDR_W-1:0]              mem_waddr,
   output logic      [7:0]                     mem_wdata,
   output logic                                mem_re,
   output logic      [ADDR_W-1:0]              mem_raddr,
   output i2cs_pkg::result_type                result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ADDR   = 3'd1,
      PH_CHKACK = 3'd2,
      PH_SEND   = 3'd3,
      PH_GETACK = 3'd4,
      PH_REQ    = 3'd5,
      PH_GET    = 3'd6,
      PH_ABORT  = 3'd7
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [7:0]                  ticks_ff, ticks_in;
   logic [7:0]                  rx_pos_ff, rx_pos_in;
   logic [i2cs_pkg::LEN_W-1:0]  tx_pos_ff, tx_pos_in;
   logic [i2cs_pkg::LEN_W-1:0]  tx_len_ff, tx_len_in;
   logic [i2cs_pkg::LEN_W-1:0]  staged_ff, staged_in;
   logic                        win_drive_ff, win_drive_in;
   logic [7:0]                  win_value_ff, win_value_in;
   logic [3:0]                  win_bits_ff, win_bits_in;
   logic                        win_mem_ff, win_mem_in;
   logic [6:0]                  own_addr_ff;
   logic [7:0]                  timeout_top_ff;

   logic       want_send;
   logic       send_ok;
   logic       addr_hit;
   logic       load_we;
   logic       read_req;
   logic [7:0] tick_sum;
   logic       rx_valid;
   logic       addressed_read;
   logic       timed_out;

   // Next state for one event
   always_comb begin
      phase_in       = phase_ff;
      ticks_in       = ticks_ff;
      rx_pos_in      = rx_pos_ff;
      tx_pos_in      = tx_pos_ff;
      tx_len_in      = tx_len_ff;
      staged_in      = staged_ff;
      win_drive_in   = win_drive_ff;
      win_value_in   = win_value_ff;
      win_bits_in    = win_bits_ff;
      win_mem_in     = win_mem_ff;
      want_send      = 1'b0;
      load_we        = 1'b0;
      read_req       = 1'b0;
      rx_valid       = 1'b0;
      addressed_read = 1'b0;
      timed_out      = 1'b0;
      tick_sum       = ticks_ff + 8'd1;
      send_ok        = (tx_pos_ff < tx_len_ff) && (32'(tx_pos_ff) < TX_DEPTH);
      addr_hit       = (shift_data == i2cs_pkg::GENERAL_CALL)
                       || (shift_data[7:1] == own_addr_ff);

      unique case (func)
         i2cs_pkg::FUNC_START: begin
            ticks_in     = '0;
            phase_in     = PH_ADDR;
            win_drive_in = 1'b0;
            win_value_in = '0;
            win_bits_in  = i2cs_pkg::BITS_DATA;
            win_mem_in   = 1'b0;
         end
         i2cs_pkg::FUNC_SHIFT: begin
            ticks_in = '0;
            unique case (phase_ff)
               PH_ADDR: begin
                  if (addr_hit) begin
                     if (shift_data[0]) begin
                        phase_in       = PH_SEND;
                        tx_pos_in      = '0;
                        tx_len_in      = staged_ff;
                        addressed_read = 1'b1;
                     end else begin
                        phase_in  = PH_REQ;
                        rx_pos_in = '0;
                     end
                     win_drive_in = 1'b1;
                     win_value_in = i2cs_pkg::ACK_BYTE;
                     win_bits_in  = i2cs_pkg::BITS_ACK;
                     win_mem_in   = 1'b0;
                  end else begin
                     phase_in     = PH_IDLE;
                     win_drive_in = 1'b0;
                     win_value_in = '0;
                     win_bits_in  = i2cs_pkg::BITS_NONE;
                     win_mem_in   = 1'b0;
                  end
               end
               PH_CHKACK: begin
                  if (shift_data != i2cs_pkg::ACK_BYTE) begin
                     phase_in     = PH_IDLE;
                     win_drive_in = 1'b0;
                     win_value_in = '0;
                     win_bits_in  = i2cs_pkg::BITS_NONE;
                     win_mem_in   = 1'b0;
                  end else begin
                     want_send = 1'b1;
                  end
               end
               PH_SEND: begin
                  want_send = 1'b1;
               end
               PH_GETACK: begin
                  phase_in     = PH_CHKACK;
                  win_drive_in = 1'b0;
                  win_value_in = '0;
                  win_bits_in  = i2cs_pkg::BITS_ACK;
                  win_mem_in   = 1'b0;
               end
               PH_REQ: begin
                  phase_in     = PH_GET;
                  win_drive_in = 1'b0;
                  win_value_in = '0;
                  win_bits_in  = i2cs_pkg::BITS_DATA;
                  win_mem_in   = 1'b0;
               end
               PH_GET: begin
                  rx_valid     = 1'b1;
                  rx_pos_in    = rx_pos_ff + 8'd1;
                  win_drive_in = 1'b1;
                  win_bits_in  = i2cs_pkg::BITS_ACK;
                  win_mem_in   = 1'b0;
                  if (reject) begin
                     phase_in     = PH_ABORT;
                     win_value_in = i2cs_pkg::NACK_BYTE;
                  end else begin
                     phase_in     = PH_REQ;
                     win_value_in = i2cs_pkg::ACK_BYTE;
                  end
               end
               PH_ABORT: begin
                  phase_in     = PH_IDLE;
                  win_drive_in = 1'b0;
                  win_value_in = '0;
                  win_bits_in  = i2cs_pkg::BITS_NONE;
                  win_mem_in   = 1'b0;
               end
               default: begin
                  // idle: hold the window
               end
            endcase
         end
         i2cs_pkg::FUNC_TICK: begin
            if (phase_ff != PH_IDLE) begin
               ticks_in = tick_sum;
               if (tick_sum > timeout_top_ff) begin
                  phase_in     = PH_IDLE;
                  win_drive_in = 1'b0;
                  win_value_in = '0;
                  win_bits_in  = i2cs_pkg::BITS_NONE;
                  win_mem_in   = 1'b0;
                  timed_out    = 1'b1;
               end
            end
         end
         i2cs_pkg::FUNC_LOAD: begin
            load_we = (32'(tx_index) < TX_DEPTH);
            if (32'(tx_count) > TX_DEPTH) begin
               staged_in = i2cs_pkg::LEN_W'(TX_DEPTH);
            end else begin
               staged_in = tx_count;
            end
         end
         default: begin
         end
      endcase

      // Send the next staged byte from the buffer, or drop to idle
      if (want_send) begin
         if (send_ok) begin
            read_req     = 1'b1;
            tx_pos_in    = tx_pos_ff + 1'b1;
            phase_in     = PH_GETACK;
            win_drive_in = 1'b1;
            win_value_in = '0;
            win_bits_in  = i2cs_pkg::BITS_DATA;
            win_mem_in   = 1'b1;
         end else begin
            phase_in     = PH_IDLE;
            win_drive_in = 1'b0;
            win_value_in = '0;
            win_bits_in  = i2cs_pkg::BITS_NONE;
            win_mem_in   = 1'b0;
         end
      end
   end

   // Buffer port requests
   assign mem_we    = step && load_we;
   assign mem_waddr = ADDR_W'(tx_index);
   assign mem_wdata = tx_byte;
   assign mem_re    = step && read_req;
   assign mem_raddr = ADDR_W'(tx_pos_ff);

   // Result of the current event
   always_comb begin
      result.bus_phase      = phase_in;
      result.sda_drive      = win_drive_in;
      result.shift_value    = win_value_in;
      result.shift_bits     = win_bits_in;
      result.from_mem       = win_mem_in;
      result.rx_valid       = rx_valid;
      result.rx_byte        = rx_valid ? shift_data : 8'd0;
      result.rx_index       = rx_valid ? rx_pos_ff : 8'd0;
      result.addressed_read = addressed_read;
      result.timed_out      = timed_out;
   end

   // Hold state; advance on each accepted beat and on csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_ADDR;
         ticks_ff       <= '0;
         rx_pos_ff      <= '0;
         tx_pos_ff      <= '0;
         tx_len_ff      <= '0;
         staged_ff      <= '0;
         win_drive_ff   <= 1'b0;
         win_value_ff   <= '0;
         win_bits_ff    <= i2cs_pkg::BITS_NONE;
         win_mem_ff     <= 1'b0;
         own_addr_ff    <= '0;
         timeout_top_ff <= i2cs_pkg::TIMEOUT_RESET;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            rx_pos_ff    <= rx_pos_in;
            tx_pos_ff    <= tx_pos_in;
            tx_len_ff    <= tx_len_in;
            staged_ff    <= staged_in;
            win_drive_ff <= win_drive_in;
            win_value_ff <= win_value_in;
            win_bits_ff  <= win_bits_in;
            win_mem_ff   <= win_mem_in;
         end
         // Clear the tick count on a tick-limit write, else advance with the event
         if (csr_we && (csr_index == i2cs_pkg::REG_TIMEOUT_TOP)) begin
            ticks_ff <= '0;
         end else if (step) begin
            ticks_ff <= ticks_in;
         end
         if (csr_we) begin
            case (csr_index)
               i2cs_pkg::REG_OWN_ADDRESS: begin
                  own_addr_ff <= csr_wdata[6:0];
               end
               i2cs_pkg::REG_TIMEOUT_TOP: begin
                  timeout_top_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_tx_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      tx_pos_ff <= tx_len_ff)
      else $error("transmit position ran past the latched length");

   a_rx_acks: assert property (@(posedge clock) disable iff (reset)
      step && result.rx_valid |-> result.sda_drive && result.shift_bits == i2cs_pkg::BITS_ACK)
      else $error("received byte not followed by an ack window");

   a_timeout_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.timed_out |-> result.bus_phase == PH_IDLE && !result.sda_drive)
      else $error("timeout did not release the bus");
`endif

endmodule

`default_nettype wire
